@@ rtl/jcse_pkg.sv @@
// shared types, constants and helper functions for the json content string extractor
package jcse_pkg;

    // key matching
    localparam int KEY_LEN = 9;
    localparam int POS_W   = 4;

    // result queue sizing
    localparam int MAX_RES    = 4;
    localparam int RES_CNT_W  = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // characters of interest
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // utf-8 encoding constants
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_ONE_MAX = 16'h0080;
    localparam logic [15:0] CP_TWO_MAX = 16'h0800;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    typedef enum logic [3:0] {
        PH_CHOICES,
        PH_MESSAGE,
        PH_CONTENT,
        PH_COLON,
        PH_QUOTE,
        PH_STRING,
        PH_ESCAPE,
        PH_HEX,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [1:0] status_code;
        logic       out_last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0]   items;
        logic [RES_CNT_W-1:0] cnt;
    } res_bundle_t;

    localparam logic [7:0] KEY_CHOICES [KEY_LEN] =
        '{8'h22, 8'h63, 8'h68, 8'h6F, 8'h69, 8'h63, 8'h65, 8'h73, 8'h22};
    localparam logic [7:0] KEY_MESSAGE [KEY_LEN] =
        '{8'h22, 8'h6D, 8'h65, 8'h73, 8'h73, 8'h61, 8'h67, 8'h65, 8'h22};
    localparam logic [7:0] KEY_CONTENT [KEY_LEN] =
        '{8'h22, 8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h22};

    // expected key character for the current search phase
    function automatic logic [7:0] key_char(input phase_t ph, input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < POS_W'(KEY_LEN)) begin
            case (ph)
                PH_CHOICES: c = KEY_CHOICES[pos];
                PH_MESSAGE: c = KEY_MESSAGE[pos];
                PH_CONTENT: c = KEY_CONTENT[pos];
                default:    c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // hex digit value, zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            v = 4'(b - 8'h30);
        end else if (b inside {[8'h61:8'h66]}) begin
            v = 4'(b - 8'h57);
        end else if (b inside {[8'h41:8'h46]}) begin
            v = 4'(b - 8'h37);
        end
        return v;
    endfunction

endpackage

@@ rtl/json_content_string_extractor_top.sv @@
// Top level of the json content string extractor.
// Input channel (s_): one byte of a response body per transaction, s_in_last
// marks the final byte. Result channel (m_): decoded utf-8 bytes of the
// "content" string, then one status transaction (m_is_status = 1,
// m_out_last = 1) carrying 0 ok, 1 key, colon or quote missing, 2 empty string.
// Latency: with the result queue empty, the first result of a byte is offered
// on m_ the cycle after the byte is accepted; later results queue behind it.
// Throughput: one byte per cycle while s_ready is high; a byte gives zero to
// four results (a \u escape up to three bytes, plus status on the final byte),
// drained one per cycle while m_ready is high via an eight-entry result queue.
// s_ready is high while the queue has at least four free entries, so a
// stalled receiver fills the queue and then holds off the sender; no
// transaction is lost. Reset (aresetn low, synchronous) holds s_ready low,
// empties the queue and returns the parser to searching for the first key.
// After each final byte the parser returns to that state for the next body.
module json_content_string_extractor_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_status,
    output logic [1:0] m_status_code,
    output logic       m_out_last
);
    import jcse_pkg::*;

    res_bundle_t results;
    res_t        m_item;
    logic        accept;
    logic        has_room;

    assign s_ready = has_room && aresetn;
    assign accept  = s_valid && s_ready;

    // byte parser and decoder
    jcse_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .results (results)
    );

    // result queue
    jcse_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (results),
        .has_room  (has_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    assign m_out_byte    = m_item.out_byte;
    assign m_is_status   = m_item.is_status;
    assign m_status_code = m_item.status_code;
    assign m_out_last    = m_item.out_last;

endmodule

@@ rtl/jcse_parser.sv @@
// parser state machine: key search, string unescape and utf-8 encoding
module jcse_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output jcse_pkg::res_bundle_t results
);
    import jcse_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  match_pos_reg, match_pos_next;
    logic [2:0]        hex_count_reg, hex_count_next;
    logic [15:0]       code_point_reg, code_point_next;
    logic              any_emitted_reg, any_emitted_next;

    logic [POS_W-1:0]  key_adv;
    logic [15:0]       cp_shift;
    logic [2:0]        hex_inc;
    logic [7:0]        data [3];
    logic [1:0]        ndata;
    logic              emitted;
    logic              reached;
    res_t              st_item;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_CHOICES;
            match_pos_reg   <= '0;
            hex_count_reg   <= '0;
            code_point_reg  <= '0;
            any_emitted_reg <= 1'b0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            match_pos_reg   <= match_pos_next;
            hex_count_reg   <= hex_count_next;
            code_point_reg  <= code_point_next;
            any_emitted_reg <= any_emitted_next;
        end
    end

    // next state and decoded bytes
    always_comb begin
        phase_next      = phase_reg;
        match_pos_next  = match_pos_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        data[0]         = 8'h00;
        data[1]         = 8'h00;
        data[2]         = 8'h00;
        ndata           = 2'd0;

        // key match advance, restarting on a quote
        if (match_pos_reg < POS_W'(KEY_LEN) && in_byte == key_char(phase_reg, match_pos_reg))
            key_adv = match_pos_reg + POS_W'(1);
        else if (in_byte == CH_QUOTE)
            key_adv = POS_W'(1);
        else
            key_adv = '0;

        cp_shift = {code_point_reg[11:0], hex_value(in_byte)};
        hex_inc  = hex_count_reg + 3'd1;

        case (phase_reg)
            PH_CHOICES, PH_MESSAGE, PH_CONTENT: begin
                match_pos_next = key_adv;
                if (key_adv == POS_W'(KEY_LEN)) begin
                    case (phase_reg)
                        PH_CHOICES: begin
                            phase_next     = PH_MESSAGE;
                            match_pos_next = POS_W'(1);
                        end
                        PH_MESSAGE: begin
                            phase_next     = PH_CONTENT;
                            match_pos_next = POS_W'(1);
                        end
                        default: begin
                            phase_next     = PH_COLON;
                            match_pos_next = '0;
                        end
                    endcase
                end
            end
            PH_COLON: begin
                if (in_byte == CH_COLON) phase_next = PH_QUOTE;
            end
            PH_QUOTE: begin
                if (in_byte == CH_QUOTE) phase_next = PH_STRING;
            end
            PH_STRING: begin
                if (in_byte == CH_QUOTE) begin
                    phase_next = PH_DONE;
                end else if (in_byte == CH_BACKSLASH && !in_last) begin
                    phase_next = PH_ESCAPE;
                end else begin
                    data[0] = in_byte;
                    ndata   = 2'd1;
                end
            end
            PH_ESCAPE: begin
                phase_next = PH_STRING;
                ndata      = 2'd1;
                case (in_byte)
                    CH_N:    data[0] = CH_LF;
                    CH_R:    data[0] = CH_CR;
                    CH_T:    data[0] = CH_TAB;
                    CH_U: begin
                        phase_next      = PH_HEX;
                        hex_count_next  = '0;
                        code_point_next = '0;
                        ndata           = 2'd0;
                    end
                    default: data[0] = in_byte;
                endcase
            end
            PH_HEX: begin
                code_point_next = cp_shift;
                hex_count_next  = hex_inc;
                if (hex_inc >= 3'd4) begin
                    hex_count_next = '0;
                    phase_next     = PH_STRING;
                    if (cp_shift < CP_ONE_MAX) begin
                        data[0] = cp_shift[7:0];
                        ndata   = 2'd1;
                    end else if (cp_shift < CP_TWO_MAX) begin
                        data[0] = UTF8_LEAD2 | {3'b000, cp_shift[10:6]};
                        data[1] = UTF8_CONT | {2'b00, cp_shift[5:0]};
                        ndata   = 2'd2;
                    end else begin
                        data[0] = UTF8_LEAD3 | {4'h0, cp_shift[15:12]};
                        data[1] = UTF8_CONT | {2'b00, cp_shift[11:6]};
                        data[2] = UTF8_CONT | {2'b00, cp_shift[5:0]};
                        ndata   = 2'd3;
                    end
                end
            end
            default: phase_next = PH_DONE;
        endcase

        emitted          = any_emitted_reg || (ndata != 2'd0);
        any_emitted_next = emitted;
        reached          = (phase_next >= PH_STRING);

        // final status transaction
        st_item.out_byte  = 8'h00;
        st_item.is_status = 1'b1;
        st_item.out_last  = 1'b1;
        if (!reached)     st_item.status_code = ST_NOT_FOUND;
        else if (emitted) st_item.status_code = ST_OK;
        else              st_item.status_code = ST_EMPTY;

        // assemble result transactions
        results.items = '0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < ndata) begin
                results.items[i].out_byte = data[i];
            end
        end
        results.cnt = {1'b0, ndata};
        if (in_last) begin
            results.items[ndata] = st_item;
            results.cnt          = {1'b0, ndata} + RES_CNT_W'(1);
        end

        // end of body returns to the search for the first key
        if (in_last) begin
            phase_next       = PH_CHOICES;
            match_pos_next   = '0;
            hex_count_next   = '0;
            code_point_next  = '0;
            any_emitted_next = 1'b0;
        end
    end

endmodule

@@ rtl/jcse_result_fifo.sv @@
// result queue taking up to four transactions per cycle and giving one per cycle while m_ready is high
module jcse_result_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  jcse_pkg::res_bundle_t push_data,
    output logic                  has_room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output jcse_pkg::res_t        m_item
);
    import jcse_pkg::*;

    res_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [RES_CNT_W-1:0] push_cnt;
    logic               pop;

    // occupancy and pointer update
    always_comb begin
        push_cnt    = push ? push_data.cnt : '0;
        pop         = m_valid && m_ready;
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (push && RES_CNT_W'(i) < push_data.cnt) begin
                mem_reg[wr_ptr_reg + FIFO_AW'(i)] <= push_data.items[i];
            end
        end
    end

    // room for a worst-case input byte
    assign has_room = (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RES));
    assign m_valid  = (count_reg != '0);
    assign m_item   = mem_reg[rd_ptr_reg];

endmodule

@@ bench/json_content_string_extractor_top_tb.sv @@
// self-checking testbench for the json content string extractor top level
`timescale 1ns / 1ps

module json_content_string_extractor_top_tb;

    import jcse_pkg::*;

    localparam int QUIET_TAIL   = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int TOTAL_BYTES  = 320;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } body_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_is_status;
    logic [1:0] m_status_code;
    logic       m_out_last;

    // stimulus and expected decoded output
    body_byte_t pending_q[$];
    logic [7:0] body[$];
    res_t       decoded_q[$];
    body_byte_t next_tx;
    res_t       want;

    // parser state mirrored by the predictor
    phase_t      cur_phase = PH_CHOICES;
    logic [3:0]  key_pos = '0;
    int          hex_seen = 0;
    logic [15:0] cp_acc = '0;
    bit          any_out = 1'b0;

    string key_text [3] = '{"\"choices\"", "\"message\"", "\"content\""};

    int  send_gap = 0;
    int  ready_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  bytes_taken = 0;
    int  error_count = 0;
    int  idle_cycles = 0;
    int  kind;
    int  cut;

    json_content_string_extractor_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_status   (m_is_status),
        .m_status_code (m_status_code),
        .m_out_last    (m_out_last)
    );

    always #5 aclk = ~aclk;

    task automatic flag_error(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // advance a key match; a quote that breaks a match starts a new one
    function automatic logic [3:0] key_step(input phase_t ph, input logic [3:0] pos,
                                            input logic [7:0] b);
        logic [7:0] want_ch;
        want_ch = 8'h00;
        if (pos < KEY_LEN) want_ch = key_text[int'(ph)][pos];
        if (pos < KEY_LEN && b == want_ch) return pos + 4'd1;
        return (b == CH_QUOTE) ? 4'd1 : 4'd0;
    endfunction

    // hex digit weight, anything else weighs zero
    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 4'(b - "0");
        if (b >= "a" && b <= "f") return 4'(b - "a" + 8'd10);
        if (b >= "A" && b <= "F") return 4'(b - "A" + 8'd10);
        return 4'd0;
    endfunction

    task automatic push_data(input logic [7:0] v);
        res_t r;
        r.out_byte    = v;
        r.is_status   = 1'b0;
        r.status_code = ST_OK;
        r.out_last    = 1'b0;
        decoded_q.push_back(r);
        any_out = 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        res_t r;
        case (cur_phase)
            PH_CHOICES, PH_MESSAGE, PH_CONTENT: begin
                key_pos = key_step(cur_phase, key_pos, b);
                if (key_pos == KEY_LEN) begin
                    // the closing quote doubles as the next key's opening quote
                    key_pos = 4'd1;
                    if (cur_phase == PH_CHOICES) begin
                        cur_phase = PH_MESSAGE;
                    end else if (cur_phase == PH_MESSAGE) begin
                        cur_phase = PH_CONTENT;
                    end else begin
                        cur_phase = PH_COLON;
                        key_pos = 4'd0;
                    end
                end
            end
            PH_COLON: begin
                if (b == CH_COLON) cur_phase = PH_QUOTE;
            end
            PH_QUOTE: begin
                if (b == CH_QUOTE) cur_phase = PH_STRING;
            end
            PH_STRING: begin
                if (b == CH_QUOTE) cur_phase = PH_DONE;
                else if (b == CH_BACKSLASH && !last) cur_phase = PH_ESCAPE;
                else push_data(b);
            end
            PH_ESCAPE: begin
                cur_phase = PH_STRING;
                case (b)
                    CH_N: push_data(CH_LF);
                    CH_R: push_data(CH_CR);
                    CH_T: push_data(CH_TAB);
                    CH_U: begin
                        cur_phase = PH_HEX;
                        hex_seen = 0;
                        cp_acc = '0;
                    end
                    default: push_data(b);
                endcase
            end
            PH_HEX: begin
                cp_acc = {cp_acc[11:0], nibble_of(b)};
                hex_seen++;
                if (hex_seen >= 4) begin
                    hex_seen = 0;
                    cur_phase = PH_STRING;
                    // utf-8 encode the assembled code point
                    if (cp_acc < CP_ONE_MAX) begin
                        push_data(cp_acc[7:0]);
                    end else if (cp_acc < CP_TWO_MAX) begin
                        push_data(UTF8_LEAD2 | {3'b000, cp_acc[10:6]});
                        push_data(UTF8_CONT | {2'b00, cp_acc[5:0]});
                    end else begin
                        push_data(UTF8_LEAD3 | {4'b0000, cp_acc[15:12]});
                        push_data(UTF8_CONT | {2'b00, cp_acc[11:6]});
                        push_data(UTF8_CONT | {2'b00, cp_acc[5:0]});
                    end
                end
            end
            default: cur_phase = PH_DONE;
        endcase

        // final byte: status, then back to searching for the first key
        if (last) begin
            r.out_byte  = 8'h00;
            r.is_status = 1'b1;
            r.out_last  = 1'b1;
            if (cur_phase >= PH_STRING) r.status_code = any_out ? ST_OK : ST_EMPTY;
            else r.status_code = ST_NOT_FOUND;
            decoded_q.push_back(r);
            cur_phase = PH_CHOICES;
            key_pos = '0;
            hex_seen = 0;
            cp_acc = '0;
            any_out = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // body builders
    // ---------------------------------------------------------------

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    endtask

    task automatic add_keys(input bit compact);
        if (compact) add_text("\"choices\"message\"content\":\"");
        else add_text({"{\"id\":\"r1\",\"choices\":[{\"index\":0,\"message\":",
                       "{\"role\":\"assistant\",\"content\": \""});
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) return "0" + 8'(v);
        return (upper ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    // one piece of string content: plain byte, escape or unicode escape
    task automatic add_token();
        string       esc_set;
        string       bad_hex;
        logic [7:0]  c;
        logic [15:0] cp;
        esc_set = "nrt\"\\/";
        bad_hex = "gxzGZ\":\\ ";
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE || c == CH_BACKSLASH);
                body.push_back(c);
            end
            5, 6: begin
                body.push_back(CH_BACKSLASH);
                body.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
            end
            7: begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_U);
                body.push_back(CH_BACKSLASH);
                body.push_back(c);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                body.push_back(CH_BACKSLASH);
                body.push_back(CH_U);
                for (int i = 3; i >= 0; i--) begin
                    if ($urandom_range(0, 11) == 0)
                        body.push_back(bad_hex[$urandom_range(0, bad_hex.len() - 1)]);
                    else
                        body.push_back(hex_char(cp[4*i +: 4], $urandom_range(0, 1)));
                end
            end
        endcase
    endtask

    task automatic add_tokens(input int n);
        for (int i = 0; i < n; i++) add_token();
    endtask

    // move the body into the send queue, final byte flagged
    task automatic flush_body();
        body_byte_t t;
        for (int i = 0; i < body.size(); i++) begin
            t.b = body[i];
            t.last = (i == body.size() - 1);
            pending_q.push_back(t);
        end
        body.delete();
    endtask

    // ---------------------------------------------------------------
    // stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial begin
        // directed bodies
        body.push_back(8'hFF);
        flush_body();
        body.push_back(8'h00);
        flush_body();
        add_keys(1); add_text("\"");
        flush_body();
        add_keys(1);
        add_text({"A\\n\\r\\t\\\"\\\\\\/\\q\\u0041\\u00e9\\u07FF\\u0800\\uFFFF",
                  "\\u007f\\u0080\\uzz4G\\u\"12\"ok\"}"});
        flush_body();
        add_keys(1); add_text("x\\");
        flush_body();
        add_keys(1); add_text("\\u12");
        flush_body();
        add_text("\"\"choices\"\"message\"\"content\" :");
        flush_body();
        add_keys(1); add_text("\\t");
        flush_body();
        add_text("\"choices\"");
        flush_body();

        // random bodies, mostly well formed
        while (pending_q.size() < TOTAL_BYTES) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1, 2, 3, 4, 5, 7: begin
                    if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 4));
                    add_keys($urandom_range(0, 1));
                    add_tokens($urandom_range(0, 10));
                    add_text("\"");
                    add_noise($urandom_range(0, 5));
                    if (kind == 7) begin
                        // truncated anywhere
                        cut = $urandom_range(1, body.size());
                        while (body.size() > cut) void'(body.pop_back());
                    end
                end
                6: add_noise($urandom_range(1, 10));
                8: begin
                    // body ends inside a unicode escape
                    add_keys(1);
                    add_tokens($urandom_range(0, 3));
                    add_text("\\u");
                    for (int i = $urandom_range(0, 3); i > 0; i--)
                        body.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                end
                9: begin
                    add_keys($urandom_range(0, 1));
                    add_tokens($urandom_range(0, 4));
                    add_text("\\");
                end
                10: begin
                    add_text("\"choices\"mess");
                    add_noise($urandom_range(1, 6));
                end
                default: begin
                    add_keys(1);
                    add_tokens($urandom_range(0, 4));
                    body.push_back(CH_BACKSLASH);
                    body.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            flush_body();
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || decoded_q.size() != 0);
        repeat (20) @(posedge aclk);

        if (decoded_q.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", decoded_q.size()));
        if (error_count == 0) begin
            $display("json_content_string_extractor_top_tb: clean");
        end else begin
            $display("json_content_string_extractor_top_tb: errors");
        end
        $finish;
    end

    // byte driver with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'h00;
            s_in_last <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, s_in_last);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    next_tx = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_in_byte <= next_tx.b;
                    s_in_last <= next_tx.last;
                    if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            // compare each accepted transaction with the oldest expectation
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    flag_error($sformatf("unexpected result byte=%h status=%b code=%0d last=%b",
                                         m_out_byte, m_is_status, m_status_code, m_out_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.out_byte)
                        flag_error($sformatf("out_byte %h, expected %h",
                                             m_out_byte, want.out_byte));
                    if (m_is_status !== want.is_status)
                        flag_error($sformatf("is_status %b, expected %b",
                                             m_is_status, want.is_status));
                    if (m_status_code !== want.status_code)
                        flag_error($sformatf("status_code %0d, expected %0d",
                                             m_status_code, want.status_code));
                    if (m_out_last !== want.out_last)
                        flag_error($sformatf("out_last %b, expected %b",
                                             m_out_last, want.out_last));
                end
            end

            // one long hold-off to fill the result queue, then short stalls
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && bytes_taken >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                ready_gap = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a transaction", idle_cycles);
                $display("json_content_string_extractor_top_tb: errors");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

endmodule
